// ----- design/assert_macros.svh -----
// Assertion macros used by the checker file.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CHM_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, disabled during reset.
`define CHM_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ----- design/chm_pkg.sv -----
// Shared types and constants of the hash map engine.
// No dependencies.
package chm_pkg;

    localparam int OP_BITS        = 2;
    localparam int OUT_VALUE_BITS = 20;

    localparam logic [OP_BITS-1:0] OP_PUT    = 2'd0;
    localparam logic [OP_BITS-1:0] OP_GET    = 2'd1;
    localparam logic [OP_BITS-1:0] OP_REMOVE = 2'd2;

    // status of the front-to-back request queue
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

// ----- design/chm_queue.sv -----
// Two-entry request queue between front and back.
// Depends on chm_pkg (q_status_t).
module chm_queue #(
    parameter int WIDTH = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  logic [WIDTH-1:0]    push_data,
    input  logic                pop,
    output logic [WIDTH-1:0]    pop_data,
    output chm_pkg::q_status_t  q_stat
);

    logic [WIDTH-1:0] entry_reg [2];
    logic             wr_ptr_reg;
    logic             wr_ptr_next;
    logic             rd_ptr_reg;
    logic             rd_ptr_next;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;
    logic             do_push;
    logic             do_pop;

    assign q_stat.full  = (count_reg == 2'd2);
    assign q_stat.empty = (count_reg == 2'd0);
    assign do_push      = push && !q_stat.full;
    assign do_pop       = pop && !q_stat.empty;
    assign pop_data     = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- design/chm_front.sv -----
// Front end: accepts request beats and computes the bucket (key mod BUCKET_COUNT).
// Depends on chm_pkg (q_status_t, OP_BITS).
module chm_front #(
    parameter int BUCKET_COUNT = 769,
    parameter int KEY_BITS     = 20,
    parameter int VALUE_BITS   = 20,
    parameter int BKT_W        = 10,
    parameter int ENTRY_W      = chm_pkg::OP_BITS + KEY_BITS + VALUE_BITS + BKT_W
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [chm_pkg::OP_BITS-1:0] req_type,
    input  logic [KEY_BITS-1:0]         key,
    input  logic [VALUE_BITS-1:0]       new_value,
    input  logic                        clearing,
    input  chm_pkg::q_status_t          q_stat,
    output logic                        push,
    output logic [ENTRY_W-1:0]          push_data
);

    localparam int LOG_B = $clog2(BUCKET_COUNT);
    localparam int REM_W = BKT_W + 1;
    localparam int SHIFT = KEY_BITS + LOG_B;
    localparam int PW    = SHIFT + KEY_BITS;
    // floor(2^SHIFT / B): the estimated quotient is low by at most one
    localparam logic [63:0] RECIP64 = (64'd1 << SHIFT) / BUCKET_COUNT;
    localparam logic [PW-1:0] RECIP = PW'(RECIP64);
    localparam logic [REM_W-1:0] B_REM = REM_W'(BUCKET_COUNT);

    logic                        s1_valid_reg;
    logic                        s1_valid_next;
    logic [chm_pkg::OP_BITS-1:0] s1_op_reg;
    logic [KEY_BITS-1:0]         s1_key_reg;
    logic [VALUE_BITS-1:0]       s1_val_reg;
    logic [PW-1:0]               s1_prod_reg;
    logic [PW-1:0]               s1_prod_next;

    logic                        s2_valid_reg;
    logic [chm_pkg::OP_BITS-1:0] s2_op_reg;
    logic [KEY_BITS-1:0]         s2_key_reg;
    logic [VALUE_BITS-1:0]       s2_val_reg;
    logic [REM_W-1:0]            s2_rem_reg;
    logic [REM_W-1:0]            s2_rem_next;

    logic [KEY_BITS-1:0]         quot;
    logic [REM_W-1:0]            rem_fix;
    logic [BKT_W-1:0]            bucket;
    logic                        advance;

    assign advance       = !s2_valid_reg || !q_stat.full;
    assign in_stall      = clearing || !advance;
    assign s1_valid_next = in_valid && !in_stall;
    assign s1_prod_next  = PW'(key) * RECIP;

    assign quot = s1_prod_reg[PW-1:SHIFT];
    // remainder < 2B, so REM_W-bit wraparound arithmetic is exact
    assign s2_rem_next = REM_W'(s1_key_reg) - REM_W'(REM_W'(quot) * B_REM);

    assign rem_fix   = (s2_rem_reg >= B_REM) ? (s2_rem_reg - B_REM) : s2_rem_reg;
    assign bucket    = rem_fix[BKT_W-1:0];
    assign push      = s2_valid_reg && !q_stat.full;
    assign push_data = {s2_op_reg, s2_key_reg, s2_val_reg, bucket};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_op_reg   <= req_type;
            s1_key_reg  <= key;
            s1_val_reg  <= new_value;
            s1_prod_reg <= s1_prod_next;
            s2_op_reg   <= s1_op_reg;
            s2_key_reg  <= s1_key_reg;
            s2_val_reg  <= s1_val_reg;
            s2_rem_reg  <= s2_rem_next;
        end
    end

endmodule

// ----- design/chm_back.sv -----
// Back end: bucket row memory, clearing pass, read-compare-write sequencer, result register.
// Depends on chm_pkg (op codes, q_status_t, OUT_VALUE_BITS).
module chm_back #(
    parameter int BUCKET_COUNT    = 769,
    parameter int WAYS_PER_BUCKET = 4,
    parameter int KEY_BITS        = 20,
    parameter int VALUE_BITS      = 20,
    parameter int BKT_W           = 10,
    parameter int ENTRY_W         = chm_pkg::OP_BITS + KEY_BITS + VALUE_BITS + BKT_W
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  chm_pkg::q_status_t                q_stat,
    input  logic [ENTRY_W-1:0]                pop_data,
    output logic                              pop,
    output logic                              clearing,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              found,
    output logic [chm_pkg::OUT_VALUE_BITS-1:0] value_out,
    output logic                              bucket_full
);

    localparam int WAY_W  = 1 + KEY_BITS + VALUE_BITS;
    localparam int ROW_W  = WAY_W * WAYS_PER_BUCKET;
    localparam int WAY_IW = (WAYS_PER_BUCKET > 1) ? $clog2(WAYS_PER_BUCKET) : 1;

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_READ  = 2'd1;
    localparam logic [1:0] ST_EXEC  = 2'd2;

    logic [ROW_W-1:0]  bucket_mem [BUCKET_COUNT];
    logic [ROW_W-1:0]  rd_data_reg;

    logic [1:0]        state_reg;
    logic [1:0]        state_next;
    logic [BKT_W-1:0]  clr_cnt_reg;
    logic [BKT_W-1:0]  clr_cnt_next;

    logic [chm_pkg::OP_BITS-1:0] op_w_reg;
    logic [KEY_BITS-1:0]         key_w_reg;
    logic [VALUE_BITS-1:0]       val_w_reg;
    logic [BKT_W-1:0]            bkt_w_reg;

    logic [chm_pkg::OP_BITS-1:0] q_op;
    logic [KEY_BITS-1:0]         q_key;
    logic [VALUE_BITS-1:0]       q_val;
    logic [BKT_W-1:0]            q_bkt;

    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic                        found_reg;
    logic                        found_next;
    logic [chm_pkg::OUT_VALUE_BITS-1:0] value_out_reg;
    logic [chm_pkg::OUT_VALUE_BITS-1:0] value_out_next;
    logic                        full_reg;
    logic                        full_next;

    logic                        way_v   [WAYS_PER_BUCKET];
    logic [KEY_BITS-1:0]         way_k   [WAYS_PER_BUCKET];
    logic [VALUE_BITS-1:0]       way_d   [WAYS_PER_BUCKET];
    logic [WAYS_PER_BUCKET-1:0]  hit_vec;
    logic [WAYS_PER_BUCKET-1:0]  free_vec;
    logic [WAY_IW-1:0]           hit_idx;
    logic [WAY_IW-1:0]           free_idx;
    logic                        any_hit;
    logic                        any_free;
    logic [ROW_W-1:0]            row_next;

    logic                        exec_go;
    logic                        mem_we;
    logic [BKT_W-1:0]            mem_waddr;
    logic [ROW_W-1:0]            mem_wdata;

    assign {q_op, q_key, q_val, q_bkt} = pop_data;

    assign clearing  = (state_reg == ST_CLEAR);
    assign pop       = (state_reg == ST_READ) && !q_stat.empty;
    assign exec_go   = (state_reg == ST_EXEC) && (!out_valid_reg || !out_stall);

    // way compare, lowest matching and lowest free way win
    always_comb
    begin
        hit_idx  = '0;
        free_idx = '0;
        for (int w = 0; w < WAYS_PER_BUCKET; w++)
        begin
            way_v[w]    = rd_data_reg[w*WAY_W + KEY_BITS + VALUE_BITS];
            way_k[w]    = rd_data_reg[w*WAY_W + VALUE_BITS +: KEY_BITS];
            way_d[w]    = rd_data_reg[w*WAY_W +: VALUE_BITS];
            hit_vec[w]  = way_v[w] && (way_k[w] == key_w_reg);
            free_vec[w] = !way_v[w];
        end
        for (int w = WAYS_PER_BUCKET - 1; w >= 0; w--)
        begin
            if (hit_vec[w])
            begin
                hit_idx = WAY_IW'(w);
            end
            if (free_vec[w])
            begin
                free_idx = WAY_IW'(w);
            end
        end
        any_hit  = |hit_vec;
        any_free = |free_vec;
    end

    always_comb
    begin
        row_next       = rd_data_reg;
        found_next     = 1'b0;
        value_out_next = '0;
        full_next      = 1'b0;
        unique case (op_w_reg)
            chm_pkg::OP_PUT:
            begin
                found_next = any_hit;
                full_next  = !any_hit && !any_free;
                for (int w = 0; w < WAYS_PER_BUCKET; w++)
                begin
                    if (any_hit && hit_idx == WAY_IW'(w))
                    begin
                        row_next[w*WAY_W +: VALUE_BITS] = val_w_reg;
                    end
                    else if (!any_hit && any_free && free_idx == WAY_IW'(w))
                    begin
                        row_next[w*WAY_W +: WAY_W] = {1'b1, key_w_reg, val_w_reg};
                    end
                end
            end
            chm_pkg::OP_GET:
            begin
                found_next = any_hit;
                if (any_hit)
                begin
                    value_out_next = chm_pkg::OUT_VALUE_BITS'(way_d[hit_idx]);
                end
            end
            chm_pkg::OP_REMOVE:
            begin
                found_next = any_hit;
                for (int w = 0; w < WAYS_PER_BUCKET; w++)
                begin
                    if (any_hit && hit_idx == WAY_IW'(w))
                    begin
                        row_next[w*WAY_W + KEY_BITS + VALUE_BITS] = 1'b0;
                    end
                end
            end
            default:
            begin
                // unused code: no change, all-zero result
                row_next = rd_data_reg;
            end
        endcase
    end

    assign mem_we    = clearing || exec_go;
    assign mem_waddr = clearing ? clr_cnt_reg : bkt_w_reg;
    assign mem_wdata = clearing ? '0 : row_next;

    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = BKT_W'(clr_cnt_reg + 1'b1);
                if (clr_cnt_reg == BKT_W'(BUCKET_COUNT - 1))
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                if (pop)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (exec_go)
                begin
                    state_next = ST_READ;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (exec_go)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            bucket_mem[mem_waddr] <= mem_wdata;
        end
        if (pop)
        begin
            rd_data_reg <= bucket_mem[q_bkt];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            op_w_reg  <= q_op;
            key_w_reg <= q_key;
            val_w_reg <= q_val;
            bkt_w_reg <= q_bkt;
        end
        if (exec_go)
        begin
            found_reg     <= found_next;
            value_out_reg <= value_out_next;
            full_reg      <= full_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign found       = found_reg;
    assign value_out   = value_out_reg;
    assign bucket_full = full_reg;

endmodule

// ----- design/chained_hash_map_engine.sv -----
// Top level of the chained hash map engine: front, request queue, back.
// Depends on chm_pkg, chm_front, chm_queue, chm_back.

// Key/value table: put, get or remove one key per request beat, one result beat per
// request. The bucket is key mod BUCKET_COUNT, each bucket holds WAYS_PER_BUCKET ways kept
// in one memory row and compared in parallel. A new request is not taken by the back end
// until the row read and its write-back on the single bucket memory are done. A request
// passes the modulo pipeline registers (s1, s2), the queue and the row read register;
// the result register is loaded at the write-back, which waits while a held result
// beat is stalled. After reset a clearing pass writes every row (BUCKET_COUNT rows, 769
// by default), with in_stall held high.
module chained_hash_map_engine #(
    parameter int BUCKET_COUNT    = 769,
    parameter int WAYS_PER_BUCKET = 4,
    parameter int KEY_BITS        = 20,
    parameter int VALUE_BITS      = 20
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [chm_pkg::OP_BITS-1:0]        req_type,
    input  logic [KEY_BITS-1:0]                key,
    input  logic [VALUE_BITS-1:0]              new_value,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               found,
    output logic [chm_pkg::OUT_VALUE_BITS-1:0] value_out,
    output logic                               bucket_full
);

    localparam int LOG_B   = $clog2(BUCKET_COUNT);
    localparam int BKT_W   = (LOG_B > 0) ? LOG_B : 1;
    localparam int ENTRY_W = chm_pkg::OP_BITS + KEY_BITS + VALUE_BITS + BKT_W;

    chm_pkg::q_status_t q_stat;
    logic               push;
    logic [ENTRY_W-1:0] push_data;
    logic               pop;
    logic [ENTRY_W-1:0] pop_data;
    logic               clearing;

    chm_front #(
        .BUCKET_COUNT (BUCKET_COUNT),
        .KEY_BITS     (KEY_BITS),
        .VALUE_BITS   (VALUE_BITS),
        .BKT_W        (BKT_W),
        .ENTRY_W      (ENTRY_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .req_type  (req_type),
        .key       (key),
        .new_value (new_value),
        .clearing  (clearing),
        .q_stat    (q_stat),
        .push      (push),
        .push_data (push_data)
    );

    chm_queue #(
        .WIDTH (ENTRY_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .q_stat    (q_stat)
    );

    chm_back #(
        .BUCKET_COUNT    (BUCKET_COUNT),
        .WAYS_PER_BUCKET (WAYS_PER_BUCKET),
        .KEY_BITS        (KEY_BITS),
        .VALUE_BITS      (VALUE_BITS),
        .BKT_W           (BKT_W),
        .ENTRY_W         (ENTRY_W)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_stat      (q_stat),
        .pop_data    (pop_data),
        .pop         (pop),
        .clearing    (clearing),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .found       (found),
        .value_out   (value_out),
        .bucket_full (bucket_full)
    );

endmodule

// ----- design/chm_checker.sv -----
// Port-level checks for the hash map engine, attached by bind.
// Depends on chm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module chm_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               in_stall,
    input logic                               out_valid,
    input logic                               out_stall,
    input logic                               found,
    input logic [chm_pkg::OUT_VALUE_BITS-1:0] value_out,
    input logic                               bucket_full
);

    // a held result beat keeps its payload
    `CHM_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(found) && $stable(value_out) && $stable(bucket_full))

    // a dropped put is never a put to a present key
    `CHM_ASSERT_IMP(a_full_not_found, clk, rst_n, out_valid && bucket_full, !found)

    // a returned value only comes from a hit
    `CHM_ASSERT_IMP(a_value_needs_hit, clk, rst_n, out_valid && (value_out != '0), found && !bucket_full)

    // the clearing pass blocks input right after reset
    `CHM_ASSERT_IMP(a_clear_stalls, clk, rst_n, !$past(rst_n), in_stall)

endmodule

bind chained_hash_map_engine chm_checker u_chk (.*);
